[rtl/fss_pkg.sv]
`timescale 1ns / 1ps

package fss_pkg;

  localparam int PATTERN_DEPTH       = 255;
  localparam int STRING_LENGTH_LIMIT = 65535;

  localparam int IDX_W  = $clog2(PATTERN_DEPTH);
  localparam int LEN_W  = $clog2(PATTERN_DEPTH + 1);
  localparam int SLEN_W = $clog2(STRING_LENGTH_LIMIT + 1);
  localparam int CMP_W  = (LEN_W > SLEN_W) ? LEN_W : SLEN_W;

  localparam int RS_MAX = 5 * PATTERN_DEPTH * (PATTERN_DEPTH - 1) / 2 + 30 * PATTERN_DEPTH;
  localparam int RS_W   = $clog2(RS_MAX + 1);

  localparam int PS_W    = ((RS_W > SLEN_W) ? RS_W : SLEN_W) + 2;
  localparam int SCORE_W = 19;
  localparam int CL_W    = ((PS_W > SCORE_W) ? PS_W : SCORE_W) + 1;

  localparam int SCORE_MAX = 262143;
  localparam int SCORE_MIN = -65536;

  localparam int DIV_SH    = PS_W + 1;
  localparam longint DIV_K = ((longint'(1) << DIV_SH) + 2) / 3;

  localparam int SCORE_MATCH   = 10;
  localparam int BONUS_FIRST   = 20;
  localparam int BONUS_BOUND   = 15;
  localparam int BONUS_EXACT   = 80;
  localparam int BONUS_NAME    = 50;
  localparam int SUBST_MIN_LEN = 5;

  localparam int GROUP_COUNT = 27;

  localparam logic [7:0] CH_BRACKET    = 8'h5B;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_BYTE   = 2'd2,
    OP_END    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    OUT_SCORED   = 2'd0,
    OUT_REJECTED = 2'd1,
    OUT_EMPTY    = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [RS_W-1:0]   rs;
    logic [SLEN_W-1:0] slen;
    logic              exact;
    logic              sub;
    logic              name;
    outcome_e          outcome;
  } fss_snap_t;

  typedef struct packed {
    logic s1_valid;
    logic full;
  } fss_fin_st_t;

  function automatic logic is_upper(logic [7:0] c);
    return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
  endfunction

  function automatic logic [7:0] fold(logic [7:0] c);
    return is_upper(c) ? (c + CASE_OFFSET) : c;
  endfunction

  function automatic logic [GROUP_COUNT-1:0] group_mask(logic [7:0] c);
    logic [GROUP_COUNT-1:0] m;
    m = '0;
    case (c)
      8'h61: begin m[3] = 1'b1; m[4] = 1'b1; m[13] = 1'b1; m[14] = 1'b1; m[22] = 1'b1; end
      8'h62: begin m[17] = 1'b1; m[24] = 1'b1; m[25] = 1'b1; m[26] = 1'b1; end
      8'h63: begin m[15] = 1'b1; m[23] = 1'b1; m[24] = 1'b1; m[25] = 1'b1; end
      8'h64: begin m[6] = 1'b1; m[14] = 1'b1; m[15] = 1'b1; m[16] = 1'b1; end
      8'h65: begin
        m[2] = 1'b1; m[3] = 1'b1; m[5] = 1'b1;
        m[6] = 1'b1; m[7] = 1'b1; m[15] = 1'b1;
      end
      8'h66: begin m[7] = 1'b1; m[15] = 1'b1; m[16] = 1'b1; m[17] = 1'b1; end
      8'h67: begin m[8] = 1'b1; m[16] = 1'b1; m[17] = 1'b1; m[18] = 1'b1; end
      8'h68: begin m[9] = 1'b1; m[17] = 1'b1; m[18] = 1'b1; m[19] = 1'b1; end
      8'h69: begin m[0] = 1'b1; m[2] = 1'b1; m[9] = 1'b1; m[10] = 1'b1; m[11] = 1'b1; end
      8'h6A: begin m[10] = 1'b1; m[18] = 1'b1; m[19] = 1'b1; m[20] = 1'b1; end
      8'h6B: begin m[11] = 1'b1; m[19] = 1'b1; m[20] = 1'b1; m[21] = 1'b1; end
      8'h6C: begin m[20] = 1'b1; m[21] = 1'b1; end
      8'h6D: begin m[19] = 1'b1; m[26] = 1'b1; end
      8'h6E: begin m[18] = 1'b1; m[20] = 1'b1; m[25] = 1'b1; m[26] = 1'b1; end
      8'h6F: begin m[0] = 1'b1; m[1] = 1'b1; m[10] = 1'b1; m[11] = 1'b1; m[12] = 1'b1; end
      8'h70: begin m[11] = 1'b1; m[12] = 1'b1; end
      8'h71: begin m[4] = 1'b1; m[5] = 1'b1; m[13] = 1'b1; end
      8'h72: begin m[6] = 1'b1; m[7] = 1'b1; m[8] = 1'b1; end
      8'h73: begin m[5] = 1'b1; m[13] = 1'b1; m[14] = 1'b1; m[22] = 1'b1; end
      8'h74: begin m[7] = 1'b1; m[8] = 1'b1; end
      8'h75: begin m[1] = 1'b1; m[9] = 1'b1; m[10] = 1'b1; end
      8'h76: begin m[16] = 1'b1; m[23] = 1'b1; m[24] = 1'b1; m[25] = 1'b1; end
      8'h77: begin m[4] = 1'b1; m[5] = 1'b1; m[6] = 1'b1; m[7] = 1'b1; end
      8'h78: begin m[14] = 1'b1; m[15] = 1'b1; m[22] = 1'b1; m[23] = 1'b1; m[24] = 1'b1; end
      8'h79: begin m[8] = 1'b1; m[9] = 1'b1; end
      8'h7A: begin m[13] = 1'b1; m[14] = 1'b1; m[22] = 1'b1; m[23] = 1'b1; end
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

[rtl/fuzzy_subsequence_scorer_core.sv]
`timescale 1ns / 1ps

// Fuzzy subsequence scorer. Every request (clear, append pattern byte, string
// byte, end of string) is taken at one per cycle; the next pattern byte is kept
// prefetched from the pattern RAM (one write port, one registered read port) so
// the match/advance loop never waits on a RAM read. An end-of-string request
// moves through the result stages when free: one forms the adjusted sum, a
// second divides it by three if a substitution was used and clamps into the
// output register. The input stalls only for an end-of-string request while
// both stages are full and the output stalls. No clearing pass after reset.
module fuzzy_subsequence_scorer_core
  import fss_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                op_i,
  input  logic [7:0]                ch_i,
  input  logic                      name_ctx_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SCORE_W-1:0] score_o,
  output logic [1:0]                outcome_o
);

  op_e         op;
  logic        in_fire;
  logic        end_push;
  fss_snap_t   snap;
  fss_fin_st_t fin_st;
  outcome_e    outcome;

  assign op         = op_e'(op_i);
  assign in_stall_o = (op == OP_END) && fin_st.full;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign end_push   = in_fire && (op == OP_END);

  fss_matcher u_matcher (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .op_i   (op),
    .ch_i   (ch_i),
    .name_i (name_ctx_i),
    .snap_o (snap)
  );

  fss_finish u_finish (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (end_push),
    .snap_i    (snap),
    .stall_i   (out_stall_i),
    .valid_o   (out_valid_o),
    .score_o   (score_o),
    .outcome_o (outcome),
    .st_o      (fin_st)
  );

  assign outcome_o = outcome;

  a_stall_only_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (op == OP_END))
    else $error("input stalled for a request that is not end of string");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (end_push && !fin_st.s1_valid && !out_valid_o) |=> ##1 out_valid_o)
    else $error("end-of-string result missing two cycles after request");

  a_fixed_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (outcome == OUT_EMPTY)) |-> (score_o == '0))
    else $error("empty pattern result is not zero");

  a_reject_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (outcome == OUT_REJECTED)) |-> (score_o == '1))
    else $error("rejected result is not minus one");

endmodule

[rtl/fss_ram.sv]
`timescale 1ns / 1ps

module fss_ram #(
  parameter int DEPTH = 255,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // write-through on a same-address read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/fss_matcher.sv]
`timescale 1ns / 1ps

module fss_matcher
  import fss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  op_e        op_i,
  input  logic [7:0] ch_i,
  input  logic       name_i,
  output fss_snap_t  snap_o
);

  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  cur_q, cur_d;
  logic [RS_W-1:0]   rs_q, rs_d;
  logic [LEN_W-1:0]  run_q, run_d;
  logic              sub_q, sub_d;
  logic              first_q, first_d;
  logic [7:0]        prev_q, prev_d;
  logic [SLEN_W-1:0] slen_q, slen_d;
  logic              eq_q, eq_d;
  logic              brk_q, brk_d;
  logic [7:0]        pbyte_q, pbyte_d;
  logic [7:0]        p0_q, p0_d;

  logic [7:0]        low;
  logic              cur_lt;
  logic              hit;
  logic              near;
  logic              bound;
  logic [RS_W-1:0]   inc;
  logic              we;
  logic [7:0]        rdata;
  logic [LEN_W:0]    nxt;
  logic              re;

  assign low    = fold(ch_i);
  assign cur_lt = cur_q < len_q;
  assign hit    = cur_lt && (pbyte_q == low);
  assign near   = cur_lt && !hit && !sub_q && (len_q >= LEN_W'(SUBST_MIN_LEN)) &&
                  ((group_mask(pbyte_q) & group_mask(low)) != '0);
  assign bound  = (prev_q == CH_UNDERSCORE) || (prev_q == CH_DASH) ||
                  (prev_q == CH_SPACE) || (is_upper(prev_q) && !is_upper(ch_i));

  always_comb begin
    inc = RS_W'(SCORE_MATCH) + RS_W'({run_q, 2'b00}) + RS_W'(run_q);
    if (first_q) begin
      inc = inc + RS_W'(BONUS_FIRST);
    end else if (bound) begin
      inc = inc + RS_W'(BONUS_BOUND);
    end
  end

  assign we = fire_i && (op_i == OP_APPEND) && (len_q < LEN_W'(PATTERN_DEPTH));

  always_comb begin
    len_d   = len_q;
    cur_d   = cur_q;
    rs_d    = rs_q;
    run_d   = run_q;
    sub_d   = sub_q;
    first_d = first_q;
    prev_d  = prev_q;
    slen_d  = slen_q;
    eq_d    = eq_q;
    brk_d   = brk_q;
    pbyte_d = pbyte_q;
    p0_d    = p0_q;
    if (fire_i) begin
      unique case (op_i) inside
        OP_CLEAR, OP_END: begin
          if (op_i == OP_CLEAR) begin
            len_d = '0;
          end
          cur_d   = '0;
          rs_d    = '0;
          run_d   = '0;
          sub_d   = 1'b0;
          first_d = 1'b1;
          prev_d  = '0;
          slen_d  = '0;
          eq_d    = 1'b1;
          brk_d   = 1'b0;
          pbyte_d = p0_q;
        end
        OP_APPEND: begin
          if (we) begin
            len_d = len_q + LEN_W'(1);
            if (len_q == cur_q) begin
              pbyte_d = low;
            end
            if (len_q == '0) begin
              p0_d = low;
            end
          end
        end
        OP_BYTE: begin
          if ((slen_q == '0) && (ch_i == CH_BRACKET)) begin
            brk_d = 1'b1;
          end
          eq_d = eq_q && hit && (slen_q != SLEN_W'(STRING_LENGTH_LIMIT));
          if (hit) begin
            rs_d    = rs_q + inc;
            run_d   = run_q + LEN_W'(1);
            cur_d   = cur_q + LEN_W'(1);
            pbyte_d = rdata;
          end else if (near) begin
            sub_d   = 1'b1;
            run_d   = '0;
            cur_d   = cur_q + LEN_W'(1);
            pbyte_d = rdata;
          end else if (cur_lt) begin
            run_d = '0;
          end
          first_d = 1'b0;
          prev_d  = ch_i;
          if (slen_q != SLEN_W'(STRING_LENGTH_LIMIT)) begin
            slen_d = slen_q + SLEN_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // prefetch the byte after the next cursor
  assign nxt = {1'b0, cur_d} + (LEN_W + 1)'(1);
  assign re  = nxt < (LEN_W + 1)'(PATTERN_DEPTH);

  fss_ram #(
    .DEPTH (PATTERN_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (len_q[IDX_W-1:0]),
    .wdata_i (low),
    .re_i    (re),
    .raddr_i (nxt[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      cur_q   <= '0;
      rs_q    <= '0;
      run_q   <= '0;
      sub_q   <= 1'b0;
      first_q <= 1'b1;
      prev_q  <= '0;
      slen_q  <= '0;
      eq_q    <= 1'b1;
      brk_q   <= 1'b0;
    end else begin
      len_q   <= len_d;
      cur_q   <= cur_d;
      rs_q    <= rs_d;
      run_q   <= run_d;
      sub_q   <= sub_d;
      first_q <= first_d;
      prev_q  <= prev_d;
      slen_q  <= slen_d;
      eq_q    <= eq_d;
      brk_q   <= brk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pbyte_q <= pbyte_d;
    p0_q    <= p0_d;
  end

  always_comb begin
    snap_o.rs    = rs_q;
    snap_o.slen  = slen_q;
    snap_o.exact = eq_q && (CMP_W'(slen_q) == CMP_W'(len_q));
    snap_o.sub   = sub_q;
    snap_o.name  = name_i;
    if (len_q == '0) begin
      snap_o.outcome = OUT_EMPTY;
    end else if (brk_q || cur_lt) begin
      snap_o.outcome = OUT_REJECTED;
    end else begin
      snap_o.outcome = OUT_SCORED;
    end
  end

endmodule

[rtl/fss_finish.sv]
`timescale 1ns / 1ps

module fss_finish
  import fss_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  fss_snap_t                 snap_i,
  input  logic                      stall_i,
  output logic                      valid_o,
  output logic signed [SCORE_W-1:0] score_o,
  output outcome_e                  outcome_o,
  output fss_fin_st_t               st_o
);

  logic                      s1_valid_q, s1_valid_d;
  logic [PS_W-1:0]           ps_q, ps_d;
  logic                      sub_q;
  outcome_e                  oc_q;
  logic                      out_valid_q, out_valid_d;
  logic signed [SCORE_W-1:0] score_q;
  outcome_e                  out_oc_q;

  logic                      out_free;
  logic                      move;
  logic signed [PS_W-1:0]    v;
  logic [PS_W-1:0]           mag;
  logic [PS_W+DIV_SH-1:0]    prod;
  logic [PS_W-1:0]           quo;
  logic signed [PS_W-1:0]    adj;
  logic signed [CL_W-1:0]    wide;
  logic signed [SCORE_W-1:0] fin;

  assign out_free = !out_valid_q || !stall_i;
  assign move     = s1_valid_q && out_free;

  assign ps_d = PS_W'(snap_i.rs)
              + (snap_i.exact ? PS_W'(BONUS_EXACT) : '0)
              - PS_W'(snap_i.slen)
              + (snap_i.name ? PS_W'(BONUS_NAME) : '0);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (push_i) begin
      s1_valid_d = 1'b1;
    end else if (move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // divide by 3 toward zero via reciprocal multiply on the magnitude
  assign v    = $signed(ps_q);
  assign mag  = v[PS_W-1] ? PS_W'(-v) : PS_W'(v);
  assign prod = (PS_W + DIV_SH)'(mag) * (PS_W + DIV_SH)'(DIV_K);
  assign quo  = prod[PS_W+DIV_SH-1:DIV_SH];
  assign adj  = !sub_q ? v : (v[PS_W-1] ? -$signed(quo) : $signed(quo));
  assign wide = CL_W'(adj);

  always_comb begin
    unique case (oc_q)
      OUT_EMPTY:    fin = '0;
      OUT_REJECTED: fin = '1;
      default: begin
        if (wide > $signed(CL_W'(SCORE_MAX))) begin
          fin = SCORE_W'(SCORE_MAX);
        end else if (wide < $signed(CL_W'(SCORE_MIN))) begin
          fin = SCORE_W'(SCORE_MIN);
        end else begin
          fin = wide[SCORE_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ps_q  <= ps_d;
      sub_q <= snap_i.sub;
      oc_q  <= snap_i.outcome;
    end
    if (move) begin
      score_q  <= fin;
      out_oc_q <= oc_q;
    end
  end

  assign valid_o     = out_valid_q;
  assign score_o     = score_q;
  assign outcome_o   = out_oc_q;
  assign st_o.s1_valid = s1_valid_q;
  assign st_o.full     = s1_valid_q && out_valid_q && stall_i;

endmodule
